// File: rtl/tsbd_pkg.sv
// ----------------------------------------------------------------------------
// tsbd_pkg: shared types and constants for the two-state bath derivative core
// Beat payloads, multiply-accumulate control and Q12.20 saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tsbd_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned ACC_W         = PROD_W + 2;
  localparam int unsigned SUM_W         = 48;
  localparam int unsigned FRAC_W        = 20;
  localparam int unsigned HALF_SHIFT    = FRAC_W + 1;
  localparam int unsigned MAX_MODES_DEF = 256;

  // Item kinds.
  localparam logic FUNC_SYSTEM = 1'b0;
  localparam logic FUNC_MODE   = 1'b1;

  // Positions in the state vector.
  localparam logic [IDX_W-1:0] IDX_ZERO_P1   = 10'd0;
  localparam logic [IDX_W-1:0] IDX_ZERO_X1   = 10'd1;
  localparam logic [IDX_W-1:0] IDX_ZERO_P2   = 10'd2;
  localparam logic [IDX_W-1:0] IDX_SYS_P1    = 10'd3;
  localparam logic [IDX_W-1:0] IDX_SYS_X1    = 10'd4;
  localparam logic [IDX_W-1:0] IDX_SYS_P2    = 10'd5;
  localparam logic [IDX_W-1:0] IDX_SYS_X2    = 10'd6;
  localparam logic [IDX_W-1:0] IDX_MODE_BASE = 10'd7;

  localparam logic signed [ACC_W-1:0] S32_MAX_ACC = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] S32_MIN_ACC = -S32_MAX_ACC - ACC_W'(1);
  localparam logic signed [SUM_W:0]   S48_MAX_EXT = (SUM_W + 1)'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W:0]   S48_MIN_EXT = -S48_MAX_EXT - (SUM_W + 1)'(1);

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] coord_a;
    logic signed [DATA_W-1:0] coord_b;
    logic signed [DATA_W-1:0] coord_c;
    logic signed [DATA_W-1:0] coord_d;
    logic signed [DATA_W-1:0] mode_coupling;
    logic signed [DATA_W-1:0] mode_frequency;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     final_res;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic acc_sub;
  } mac_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > S32_MAX_ACC) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (x < S32_MIN_ACC) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = DATA_W'(x);
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] x);
    logic signed [SUM_W-1:0] r;
    if (x > S48_MAX_EXT) begin
      r = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (x < S48_MIN_EXT) begin
      r = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      r = SUM_W'(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsbd_stream_if.sv
// ----------------------------------------------------------------------------
// tsbd_stream_if: valid/ready stream channel
// Carries one payload of type T per beat between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsbd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/tsbd_mac.sv
// ----------------------------------------------------------------------------
// tsbd_mac: shared signed multiply-accumulate unit
// One registered 32x32 product per cycle while mul_en is set, then an add or
// subtract of that product into a wide accumulator, written while acc_en is set.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbd_mac (
  input  logic                                      clk_i,
  input  tsbd_pkg::mac_ctrl_t                       ctrl_i,
  input  logic signed [tsbd_pkg::DATA_W-1:0]        op_a_i,
  input  logic signed [tsbd_pkg::DATA_W-1:0]        op_b_i,
  output logic signed [tsbd_pkg::PROD_W-1:0]        prod_o,
  output logic signed [tsbd_pkg::ACC_W-1:0]         sum_o
);
  import tsbd_pkg::*;

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_d   = op_a_i * op_b_i;
  assign prod_ext = ACC_W'(prod_q);
  assign acc_base = ctrl_i.acc_clr ? '0 : acc_q;
  assign sum_o    = ctrl_i.acc_sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
  assign prod_o   = prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= sum_o;
    end
  end

endmodule

`default_nettype wire

// File: rtl/two_state_bath_derivative_core.sv
// ----------------------------------------------------------------------------
// two_state_bath_derivative_core: derivative of a two-state system and bath
// Forms the Q12.20 time derivative vector of a two-state electronic system
// coupled to harmonic bath modes, one result beat per vector element.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat carries
//  --------  ---------  ---------------------------------------------------
//  in_i      sink       func, coord_a..coord_d, mode_coupling,
//                       mode_frequency, last
//  out_o     source     index, value, final_res
//  cfg_*     write      coupling_v12 (write enable and data, no index)
//
// An item is taken only while the sequencer is idle. A system item emits the
// three zero beats and builds the half difference, a bath mode item emits
// its two beats, and an item marked last adds the four system derivatives;
// each multiply is a product step, then an accumulate step, in the shared
// multiply-accumulate unit. A bath item past the mode limit yields nothing,
// or only the system derivatives if marked last. A stalled output beat holds
// the sequencer at its next result. Reset clears the stored coordinates, the
// half difference, the coupled sum, the mode count and the coupling.
// ----------------------------------------------------------------------------
`default_nettype none

module two_state_bath_derivative_core #(
  parameter int unsigned MaxModes = tsbd_pkg::MAX_MODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic signed [tsbd_pkg::DATA_W-1:0] cfg_wdata_i,
  tsbd_stream_if.sink                        in_i,
  tsbd_stream_if.source                      out_o
);
  import tsbd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxModes + 1);

  // Coarse phase of the sequencer.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_EMIT = 4'b0010,
    PH_MUL  = 4'b0100,
    PH_ACC  = 4'b1000
  } phase_e;

  // Micro-program step. The zero steps emit the three null derivatives,
  // the H steps build the half difference, the B steps serve one bath mode
  // and the Y steps produce the four system derivatives.
  typedef enum logic [19:0] {
    ST_Z0  = 20'h00001,
    ST_Z1  = 20'h00002,
    ST_Z2  = 20'h00004,
    ST_H0  = 20'h00008,
    ST_H1  = 20'h00010,
    ST_H2  = 20'h00020,
    ST_H3  = 20'h00040,
    ST_BA  = 20'h00080,
    ST_BW  = 20'h00100,
    ST_BS  = 20'h00200,
    ST_BM0 = 20'h00400,
    ST_BM1 = 20'h00800,
    ST_Y0  = 20'h01000,
    ST_Y1  = 20'h02000,
    ST_Y2  = 20'h04000,
    ST_Y3  = 20'h08000,
    ST_Y4  = 20'h10000,
    ST_Y5  = 20'h20000,
    ST_Y6  = 20'h40000,
    ST_Y7  = 20'h80000
  } step_e;

  phase_e phase_q;
  step_e  step_q;

  // Stored system state.
  logic signed [DATA_W-1:0] v_q;
  logic signed [DATA_W-1:0] p1_q, x1_q, p2_q, x2_q;
  logic signed [DATA_W-1:0] h_q;
  logic signed [SUM_W-1:0]  s_q;
  logic signed [DATA_W-1:0] s_sat_q;
  logic [CntW-1:0]          cnt_q;

  // Fields of the item in flight and the squared frequency.
  logic signed [DATA_W-1:0] a_q, b_q, c_q, w_q;
  logic                     last_q;
  logic signed [DATA_W-1:0] wsq_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_data_q;

  // Shared unit connections.
  mac_ctrl_t                mac_ctrl;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum;

  logic                     acc_clr, acc_sub;
  logic                     emit_here;
  out_item_t                emit_item;
  step_e                    nxt_step;
  logic                     nxt_done;
  phase_e                   nxt_phase;

  logic                     in_fire;
  logic                     can_emit;
  logic                     emit_fire;
  logic                     acc_adv;
  logic                     step_adv;
  logic                     mode_room;
  logic signed [DATA_W-1:0] mac_val;
  logic signed [SUM_W:0]    s_sum;
  logic signed [SUM_W-1:0]  s_next;
  logic [CntW:0]            cnt_x2;
  logic [IDX_W-1:0]         idx_mode_a;
  logic [IDX_W-1:0]         idx_mode_b;

  tsbd_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .sum_o  (sum)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (phase_q == PH_IDLE);
  assign can_emit  = !out_valid_q || out_o.ready;
  assign mode_room = (cnt_q < CntW'(MaxModes));

  // Mode k lands at positions 7 + 2k and 8 + 2k.
  assign cnt_x2     = {cnt_q, 1'b0};
  assign idx_mode_a = IDX_W'(cnt_x2) + IDX_MODE_BASE;
  assign idx_mode_b = idx_mode_a + IDX_W'(1);

  // Two-product sums are floored by the arithmetic shift and then clipped.
  assign mac_val = sat32(sum >>> FRAC_W);

  // Coupled sum update: the floored product c*b joins the 48-bit sum.
  assign s_sum  = {s_q[SUM_W-1], s_q} + (SUM_W + 1)'(prod >>> FRAC_W);
  assign s_next = sat48(s_sum);

  // Operand selection, accumulate mode, result and successor of each step.
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    acc_clr   = 1'b0;
    acc_sub   = 1'b0;
    emit_here = 1'b0;
    emit_item = '{index: '0, value: '0, final_res: 1'b0};
    nxt_step  = step_q;
    nxt_done  = 1'b0;
    case (step_q)
      ST_Z0: begin
        emit_here       = 1'b1;
        emit_item.index = IDX_ZERO_P1;
        nxt_step        = ST_Z1;
      end
      ST_Z1: begin
        emit_here       = 1'b1;
        emit_item.index = IDX_ZERO_X1;
        nxt_step        = ST_Z2;
      end
      ST_Z2: begin
        emit_here       = 1'b1;
        emit_item.index = IDX_ZERO_P2;
        nxt_step        = ST_H0;
      end
      ST_H0: begin
        op_a     = p1_q;
        op_b     = p1_q;
        acc_clr  = 1'b1;
        nxt_step = ST_H1;
      end
      ST_H1: begin
        op_a     = x1_q;
        op_b     = x1_q;
        nxt_step = ST_H2;
      end
      ST_H2: begin
        op_a     = p2_q;
        op_b     = p2_q;
        acc_sub  = 1'b1;
        nxt_step = ST_H3;
      end
      ST_H3: begin
        op_a     = x2_q;
        op_b     = x2_q;
        acc_sub  = 1'b1;
        nxt_step = ST_Y0;
        nxt_done = !last_q;
      end
      ST_BA: begin
        emit_here       = 1'b1;
        emit_item.index = idx_mode_a;
        emit_item.value = a_q;
        nxt_step        = ST_BW;
      end
      ST_BW: begin
        op_a     = w_q;
        op_b     = w_q;
        acc_clr  = 1'b1;
        nxt_step = ST_BS;
      end
      ST_BS: begin
        op_a     = c_q;
        op_b     = b_q;
        acc_clr  = 1'b1;
        nxt_step = ST_BM0;
      end
      ST_BM0: begin
        op_a     = wsq_q;
        op_b     = b_q;
        acc_clr  = 1'b1;
        nxt_step = ST_BM1;
      end
      ST_BM1: begin
        op_a            = c_q;
        op_b            = h_q;
        emit_here       = 1'b1;
        emit_item.index = idx_mode_b;
        emit_item.value = mac_val;
        nxt_step        = ST_Y0;
        nxt_done        = !last_q;
      end
      ST_Y0: begin
        op_a     = v_q;
        op_b     = p2_q;
        acc_clr  = 1'b1;
        nxt_step = ST_Y1;
      end
      ST_Y1: begin
        op_a            = p1_q;
        op_b            = s_sat_q;
        emit_here       = 1'b1;
        emit_item.index = IDX_SYS_P1;
        emit_item.value = mac_val;
        nxt_step        = ST_Y2;
      end
      ST_Y2: begin
        op_a     = v_q;
        op_b     = x2_q;
        acc_clr  = 1'b1;
        nxt_step = ST_Y3;
      end
      ST_Y3: begin
        op_a            = x1_q;
        op_b            = s_sat_q;
        emit_here       = 1'b1;
        emit_item.index = IDX_SYS_X1;
        emit_item.value = mac_val;
        nxt_step        = ST_Y4;
      end
      ST_Y4: begin
        op_a     = v_q;
        op_b     = p1_q;
        acc_clr  = 1'b1;
        nxt_step = ST_Y5;
      end
      ST_Y5: begin
        op_a            = p2_q;
        op_b            = s_sat_q;
        acc_sub         = 1'b1;
        emit_here       = 1'b1;
        emit_item.index = IDX_SYS_P2;
        emit_item.value = mac_val;
        nxt_step        = ST_Y6;
      end
      ST_Y6: begin
        op_a     = v_q;
        op_b     = x1_q;
        acc_clr  = 1'b1;
        nxt_step = ST_Y7;
      end
      ST_Y7: begin
        op_a                = x2_q;
        op_b                = s_sat_q;
        acc_sub             = 1'b1;
        emit_here           = 1'b1;
        emit_item.index     = IDX_SYS_X2;
        emit_item.value     = mac_val;
        emit_item.final_res = 1'b1;
        nxt_done            = 1'b1;
      end
      default: begin
        nxt_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (nxt_done) begin
      nxt_phase = PH_IDLE;
    end else if ((nxt_step == ST_Z1) || (nxt_step == ST_Z2)) begin
      nxt_phase = PH_EMIT;
    end else begin
      nxt_phase = PH_MUL;
    end
  end

  // A step that produces a result waits until the output register is free.
  assign acc_adv   = (phase_q == PH_ACC) && (!emit_here || can_emit);
  assign step_adv  = acc_adv || ((phase_q == PH_EMIT) && can_emit);
  assign emit_fire = step_adv && emit_here;

  assign mac_ctrl = '{
    mul_en:  (phase_q == PH_MUL),
    acc_en:  acc_adv,
    acc_clr: acc_clr,
    acc_sub: acc_sub
  };

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= ST_Z0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (in_fire) begin
            if (in_i.data.func == FUNC_SYSTEM) begin
              phase_q <= PH_EMIT;
              step_q  <= ST_Z0;
            end else if (mode_room) begin
              phase_q <= PH_EMIT;
              step_q  <= ST_BA;
            end else if (in_i.data.last) begin
              // Mode limit reached: only the system derivatives follow.
              phase_q <= PH_MUL;
              step_q  <= ST_Y0;
            end
          end
        end
        PH_MUL: begin
          phase_q <= PH_ACC;
        end
        PH_EMIT, PH_ACC: begin
          if (step_adv) begin
            phase_q <= nxt_phase;
            step_q  <= nxt_step;
          end
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  // System state, coupled sum and mode count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      p1_q    <= '0;
      x1_q    <= '0;
      p2_q    <= '0;
      x2_q    <= '0;
      h_q     <= '0;
      s_q     <= '0;
      s_sat_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        v_q <= cfg_wdata_i;
      end
      if (in_fire && (in_i.data.func == FUNC_SYSTEM)) begin
        p1_q    <= in_i.data.coord_a;
        x1_q    <= in_i.data.coord_b;
        p2_q    <= in_i.data.coord_c;
        x2_q    <= in_i.data.coord_d;
        s_q     <= '0;
        s_sat_q <= '0;
        cnt_q   <= '0;
      end
      if (acc_adv) begin
        case (step_q)
          ST_H3: begin
            h_q <= sat32(sum >>> HALF_SHIFT);
          end
          ST_BS: begin
            s_q     <= s_next;
            s_sat_q <= sat32(ACC_W'(s_next));
          end
          ST_BM1: begin
            cnt_q <= cnt_q + CntW'(1);
          end
          ST_Y7: begin
            // The vector is closed: the next one starts from an empty sum.
            s_q     <= '0;
            s_sat_q <= '0;
            cnt_q   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item fields and the squared frequency carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q    <= in_i.data.coord_a;
      b_q    <= in_i.data.coord_b;
      c_q    <= in_i.data.mode_coupling;
      w_q    <= in_i.data.mode_frequency;
      last_q <= in_i.data.last;
    end
    if (acc_adv && (step_q == ST_BW)) begin
      wsq_q <= mac_val;
    end
  end

  // Output register: a new beat may be loaded in the cycle the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= emit_item;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // The mode count never passes the configured limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxModes))
    else $error("mode count beyond limit");

  // The closing beat of a vector always carries the last system position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.final_res) |-> (out_o.data.index == IDX_SYS_X2))
    else $error("final beat at wrong position");

  // When the closing beat leaves, the coupled sum and mode count are empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.final_res) |-> ((cnt_q == '0) && (s_q == '0)))
    else $error("vector state not cleared after closing beat");

endmodule

`default_nettype wire

// File: tb/two_state_bath_derivative_core_tb.sv
// ----------------------------------------------------------------------------
// two_state_bath_derivative_core_tb: self-checking bench for the bath core
// Drives system and bath mode items through the input stream, predicts every
// derivative beat in Q12.20 with exact wide arithmetic and checks the output
// stream beat by beat, under several coupling settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_state_bath_derivative_core_tb;
  import tsbd_pkg::*;

  // Run control.
  localparam int          DIR_ROWS     = 21;
  localparam int          CFG_GAP      = 40;      // covers the quiet tail after a last beat
  localparam int          DRAIN_CYCLES = 64;
  localparam int          HOLD_LEN     = 300;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // Q12.20 values used by the directed table.
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0010_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // The predictor works on 66-bit signed values, wide enough for the sum of
  // two full-range Q24.40 products without any loss.
  typedef logic signed [65:0] wide_t;
  localparam wide_t W32_HI = 66'sd2147483647;
  localparam wide_t W32_LO = -66'sd2147483648;
  localparam wide_t W48_HI = 66'sd140737488355327;
  localparam wide_t W48_LO = -66'sd140737488355328;

  // One row of stimulus. Where tcnt is non-zero, the first tcnt beat values
  // are known by inspection: v0, v1 and zero for the rest.
  typedef struct packed {
    in_item_t                 item;
    logic [2:0]               tcnt;
    logic signed [DATA_W-1:0] v0;
    logic signed [DATA_W-1:0] v1;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic signed [DATA_W-1:0] cfg_wdata;

  tsbd_stream_if #(.T(in_item_t))  in_ch ();
  tsbd_stream_if #(.T(out_item_t)) out_ch ();

  two_state_bath_derivative_core #(
    .MaxModes(MAX_MODES_DEF)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Predictor copy of the block's state and its coupling register.
  logic signed [DATA_W-1:0] cpl_v;
  logic signed [DATA_W-1:0] sys_q [4];
  logic signed [DATA_W-1:0] half_q;
  logic signed [SUM_W-1:0]  sum_q;
  int unsigned              modes_q;

  out_item_t step_beats[$];      // beats caused by the item being accepted
  out_item_t pending_derivs[$];  // derivative beats still to arrive

  int fails;
  int items_sent;
  int send_idle;                 // per cent of cycles the sender holds back
  int recv_idle;                 // per cent of cycles the receiver holds back
  bit hold_go;
  bit hold_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Exact arithmetic of the block.
  // --------------------------------------------------------------------------

  function automatic wide_t mul(input logic signed [DATA_W-1:0] x,
                                input logic signed [DATA_W-1:0] y);
    wide_t xw;
    wide_t yw;
    xw = x;
    yw = y;
    return xw * yw;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip32(input wide_t x);
    if (x > W32_HI) return S32_MAX;
    if (x < W32_LO) return S32_MIN;
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] clip48(input wide_t x);
    if (x > W48_HI) return 48'sh7FFF_FFFF_FFFF;
    if (x < W48_LO) return 48'sh8000_0000_0000;
    return x[SUM_W-1:0];
  endfunction

  // Floor of the exact sum a*b +/- c*d, rescaled to Q12.20 and saturated.
  // The arithmetic shift of the exact sum is the floor, for either sign.
  function automatic logic signed [DATA_W-1:0] mac2(input logic signed [DATA_W-1:0] a, b, c, d,
                                                    input bit sub);
    wide_t q;
    q = mul(c, d);
    if (sub) q = -q;
    return clip32((mul(a, b) + q) >>> FRAC_W);
  endfunction

  function automatic void push_beat(input logic [IDX_W-1:0] idx,
                                    input logic signed [DATA_W-1:0] v, input logic fin);
    out_item_t b;
    b.index     = idx;
    b.value     = v;
    b.final_res = fin;
    step_beats.push_back(b);
  endfunction

  // Works out the beats that one accepted item causes, and moves the state on.
  task automatic derive_beats(input in_item_t it);
    logic signed [DATA_W-1:0] wsq;
    logic signed [DATA_W-1:0] s32;
    logic [IDX_W-1:0]         idx;
    if (it.func == FUNC_SYSTEM) begin
      sys_q[0] = it.coord_a;
      sys_q[1] = it.coord_b;
      sys_q[2] = it.coord_c;
      sys_q[3] = it.coord_d;
      // Half the population difference, floored after the halving.
      half_q = clip32((mul(it.coord_a, it.coord_a) + mul(it.coord_b, it.coord_b)
                       - mul(it.coord_c, it.coord_c) - mul(it.coord_d, it.coord_d))
                      >>> HALF_SHIFT);
      sum_q   = '0;
      modes_q = 0;
      push_beat(IDX_ZERO_P1, '0, 1'b0);
      push_beat(IDX_ZERO_X1, '0, 1'b0);
      push_beat(IDX_ZERO_P2, '0, 1'b0);
    end else if (modes_q < MAX_MODES_DEF) begin
      // Beyond the mode limit a bath item leaves no mode beats and no change to the sum.
      wsq   = clip32(mul(it.mode_frequency, it.mode_frequency) >>> FRAC_W);
      idx   = IDX_MODE_BASE + IDX_W'(2 * modes_q);
      sum_q = clip48(wide_t'(sum_q) + (mul(it.mode_coupling, it.coord_b) >>> FRAC_W));
      push_beat(idx, it.coord_a, 1'b0);
      push_beat(idx + 1'b1, mac2(wsq, it.coord_b, it.mode_coupling, half_q, 1'b0), 1'b0);
      modes_q++;
    end
    if (it.last) begin
      s32 = clip32(wide_t'(sum_q));
      push_beat(IDX_SYS_P1, mac2(cpl_v, sys_q[2], sys_q[0], s32, 1'b0), 1'b0);
      push_beat(IDX_SYS_X1, mac2(cpl_v, sys_q[3], sys_q[1], s32, 1'b0), 1'b0);
      push_beat(IDX_SYS_P2, mac2(cpl_v, sys_q[0], sys_q[2], s32, 1'b1), 1'b0);
      push_beat(IDX_SYS_X2, mac2(cpl_v, sys_q[1], sys_q[3], s32, 1'b1), 1'b1);
      sum_q   = '0;
      modes_q = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction.
  // --------------------------------------------------------------------------

  // A mix of extremes, small magnitudes that keep products out of
  // saturation, and raw full-range words that toggle every bit.
  function automatic logic signed [DATA_W-1:0] rand_word();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0:       v = S32_MIN;
          1:       v = S32_MAX;
          2:       v = '0;
          3:       v = -32'sd1;
          4:       v = Q_ONE;
          default: v = -Q_ONE;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(32'h007F_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic in_item_t item_of(input logic func,
                                       input logic signed [DATA_W-1:0] a, b, c, d, cpl, frq,
                                       input logic last);
    in_item_t it;
    it.func           = func;
    it.coord_a        = a;
    it.coord_b        = b;
    it.coord_c        = c;
    it.coord_d        = d;
    it.mode_coupling  = cpl;
    it.mode_frequency = frq;
    it.last           = last;
    return it;
  endfunction

  function automatic in_item_t rand_item(input logic func, input logic last);
    return item_of(func, rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), last);
  endfunction

  function automatic stim_row_t known_row(input in_item_t it, input int n,
                                          input logic signed [DATA_W-1:0] v0,
                                          input logic signed [DATA_W-1:0] v1);
    stim_row_t r;
    r.item = it;
    r.tcnt = 3'(n);
    r.v0   = v0;
    r.v1   = v1;
    return r;
  endfunction

  function automatic stim_row_t open_row(input in_item_t it);
    return known_row(it, 0, '0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Offers one item, waits for its beat to be taken and records the beats
  // it must cause. Valid is only ever written once per time step.
  task automatic offer_item(input stim_row_t row);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= row.item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_beats.delete();
    derive_beats(row.item);
    foreach (step_beats[k]) begin
      if (k < row.tcnt) step_beats[k].value = (k == 0) ? row.v0 : (k == 1) ? row.v1 : '0;
      pending_derivs.push_back(step_beats[k]);
    end
    items_sent++;
  endtask

  // A system item followed by n_modes bath items, the last one marked.
  // A noisy vector scrambles item kinds and last flags to break the shape.
  task automatic send_vector(input int n_modes, input bit noisy);
    in_item_t it;
    for (int k = 0; k <= n_modes; k++) begin
      it = rand_item((k == 0) ? FUNC_SYSTEM : FUNC_MODE, (k == n_modes));
      if (noisy) begin
        it.func = $urandom_range(1);
        it.last = $urandom_range(1);
      end
      offer_item(open_row(it));
    end
  endtask

  // Mostly short well-formed vectors, now and then a longer one, and about
  // one in five broken up.
  task automatic run_random(input int n_items);
    int start;
    int n_modes;
    start = items_sent;
    while (items_sent - start < n_items) begin
      n_modes = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(5);
      send_vector(n_modes, $urandom_range(9) < 2);
    end
  endtask

  // The coupling is only written once the block has gone quiet: every
  // expected beat has arrived and an item with no beats has had time to end.
  task automatic set_coupling(input logic signed [DATA_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_derivs.size() != 0) @(posedge clk);
    repeat (CFG_GAP) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cpl_v = v;
  endtask

  // --------------------------------------------------------------------------
  // Output side.
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    fails++;
    $display("%0t ns: derivative mismatch: %s", $time, msg);
  endtask

  // Takes result beats, compares each with the oldest expectation, and
  // chooses the ready for the next cycle.
  initial begin : result_sink
    out_item_t got;
    out_item_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_derivs.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat, index %0d value %0d",
                                  got.index, got.value));
        end else begin
          want = pending_derivs.pop_front();
          if (got.index !== want.index)
            flag_mismatch($sformatf("index %0d, expected %0d", got.index, want.index));
          if (got.value !== want.value)
            flag_mismatch($sformatf("index %0d value %0d, expected %0d",
                                    want.index, got.value, want.value));
          if (got.final_res !== want.final_res)
            flag_mismatch($sformatf("index %0d final_res %0b, expected %0b",
                                    want.index, got.final_res, want.final_res));
        end
      end
      if (hold_on) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // One long stall of the receiver while the sender keeps offering items,
  // so that the core backs up and holds its input ready low.
  initial begin : output_hold
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Ends a run that has hung.
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------

  initial begin : stimulus
    stim_row_t dir_tab [DIR_ROWS];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    fails       = 0;
    items_sent  = 0;
    hold_go     = 1'b0;
    send_idle   = 21;
    recv_idle   = 45;
    cpl_v       = '0;
    foreach (sys_q[i]) sys_q[i] = '0;
    half_q      = '0;
    sum_q       = '0;
    modes_q     = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the coupling still at its reset value of zero.
    // The first three rows are bath items before any system item, so they
    // see the cleared coordinates and a zero half difference; the third
    // closes that vector with all-zero system derivatives.
    dir_tab = '{
      known_row(item_of(FUNC_MODE, S32_MAX, 32'sh0123_4567, S32_MIN, S32_MAX,
                        Q_ONE, '0, 1'b0), 2, S32_MAX, '0),
      known_row(item_of(FUNC_MODE, S32_MIN, 32'sh00AB_CDEF, '0, -32'sd1,
                        -32'sd1, Q_ONE, 1'b0), 2, S32_MIN, 32'sh00AB_CDEF),
      known_row(item_of(FUNC_MODE, '0, S32_MIN, rand_word(), rand_word(),
                        S32_MIN, '0, 1'b1), 6, '0, '0),
      // A system item marked last: a vector with no modes, seven zero beats.
      known_row(item_of(FUNC_SYSTEM, '0, '0, '0, '0, rand_word(), rand_word(),
                        1'b1), 7, '0, '0),
      // Full-scale coordinates that cancel exactly.
      known_row(item_of(FUNC_SYSTEM, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                        S32_MAX, S32_MAX, 1'b0), 3, '0, '0),
      // Frequency squared saturates, and so does the mode derivative.
      known_row(item_of(FUNC_MODE, -32'sd1, S32_MAX, rand_word(), rand_word(),
                        S32_MAX, S32_MAX, 1'b0), 2, -32'sd1, S32_MAX),
      // Half difference saturates high.
      known_row(item_of(FUNC_SYSTEM, S32_MIN, S32_MIN, '0, '0,
                        rand_word(), rand_word(), 1'b0), 3, '0, '0),
      known_row(item_of(FUNC_MODE, 32'sh5A5A_5A5A, S32_MIN, rand_word(), rand_word(),
                        S32_MIN, S32_MIN, 1'b1), 2, 32'sh5A5A_5A5A, S32_MIN),
      // Half difference saturates low; unit coupling passes it straight on.
      known_row(item_of(FUNC_SYSTEM, '0, '0, S32_MIN, S32_MIN,
                        rand_word(), rand_word(), 1'b0), 3, '0, '0),
      known_row(item_of(FUNC_MODE, 32'sd1, Q_ONE, rand_word(), rand_word(),
                        Q_ONE, '0, 1'b0), 2, 32'sd1, S32_MIN),
      open_row(rand_item(FUNC_MODE, 1'b0)),
      open_row(rand_item(FUNC_MODE, 1'b1)),
      open_row(rand_item(FUNC_SYSTEM, 1'b0)),
      open_row(rand_item(FUNC_MODE, 1'b0)),
      // A system item in the middle of a vector starts a fresh one.
      open_row(rand_item(FUNC_SYSTEM, 1'b0)),
      open_row(rand_item(FUNC_MODE, 1'b0)),
      open_row(rand_item(FUNC_MODE, 1'b1)),
      open_row(rand_item(FUNC_SYSTEM, 1'b1)),
      // A lone bath item marked last, straight after a closed vector.
      open_row(rand_item(FUNC_MODE, 1'b1)),
      open_row(item_of(FUNC_SYSTEM, Q_ONE, -Q_ONE, 32'sh0008_0000, 32'sh0003_0000,
                       '0, '0, 1'b0)),
      open_row(item_of(FUNC_MODE, 32'sh0002_0000, -32'sh0004_0000, rand_word(), rand_word(),
                       32'sh0001_8000, 32'sh0002_0000, 1'b1))
    };
    for (int r = 0; r < DIR_ROWS; r++) offer_item(dir_tab[r]);

    // Random part. The sender idles lightly and the receiver heavily first.
    set_coupling(S32_MAX);
    run_random(60);

    // Then the other way round, with the long receiver stall in this stretch.
    set_coupling(S32_MIN);
    send_idle = 45;
    recv_idle = 21;
    hold_go   = 1'b1;
    run_random(60);

    // No idling from here on.
    set_coupling(rand_word());
    send_idle = 0;
    recv_idle = 0;
    run_random(50);

    // One vector that runs past the mode limit, so that the surplus bath
    // items are dropped and the marked one still closes the vector.
    set_coupling(-Q_ONE);
    send_vector(MAX_MODES_DEF + 5, 1'b0);

    set_coupling(Q_ONE);
    run_random(25);

    in_ch.valid <= 1'b0;
    while (pending_derivs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0 && pending_derivs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
